/* src/dzvs_pkg.sv */
package dzvs_pkg;

  // Fraction bits of the fixed-point scale; ONE (1.0) is 2**VALUE_BITS.
  localparam int VALUE_BITS = 16;
  // Width of every value field: one integer bit above the fraction.
  localparam int W = VALUE_BITS + 1;
  // Signed width that holds the zone edges and the signed differences.
  localparam int EW = W + 3;
  // Iteration counter width for the serial divider.
  localparam int CNT_W = $clog2(W);

  localparam logic [W-1:0] ONE = {1'b1, {VALUE_BITS{1'b0}}};
  localparam logic [W-1:0] SPLIT_RST = {2'b01, {(VALUE_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD  = 2'd1;

  // Request kinds handed from the front to the back.
  localparam logic KIND_CONST = 1'b0;
  localparam logic KIND_DIV   = 1'b1;

  typedef struct packed {
    logic         kind;
    logic         port_sel;
    logic [W-1:0] num;   // numerator, or the final value for a constant request
    logic [W-1:0] den;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/dzvs_front.sv */
module dzvs_front import dzvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_data,
  output logic                 cfg_ready,
  input  logic                 in_push,
  input  logic [W-1:0]         in_sample,
  input  q_stat_t              q_stat,
  output logic                 q_push,
  output entry_t               q_entry
);

  logic [W-1:0] split_point_r, split_point_nxt;
  logic [W-1:0] dead_width_r, dead_width_nxt;
  logic [W-1:0] last_out_r, last_out_nxt;

  logic signed [EW-1:0] v_s, s_s, d_s, lo_s, hi_s, prev_s, one_s;
  logic signed [EW-1:0] num_s, den_s, den2_s;
  logic                 accept, in_zone, upper;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_stat.full;

  assign v_s    = signed'(EW'(in_sample));
  assign s_s    = signed'(EW'(split_point_r));
  assign d_s    = signed'(EW'(dead_width_r));
  assign prev_s = signed'(EW'(last_out_r));
  assign one_s  = signed'(EW'(ONE));
  assign lo_s   = s_s - d_s;
  assign hi_s   = s_s + d_s;

  assign in_zone = (v_s > lo_s) && (v_s < hi_s);
  assign upper   = !(v_s < s_s);

  always_comb begin
    if (upper) begin
      num_s = v_s - hi_s;
      den_s = one_s - hi_s;
    end else begin
      num_s = v_s;
      den_s = lo_s;
    end
    den2_s = den_s <<< 1;
  end

  always_comb begin
    q_push           = 1'b0;
    q_entry.kind     = KIND_CONST;
    q_entry.port_sel = upper;
    q_entry.num      = '0;
    q_entry.den      = den_s[W-1:0];
    last_out_nxt     = last_out_r;
    if (in_zone) begin
      // Inside the dead zone only a border value toward the last outside side.
      if (prev_s >= hi_s) begin
        q_push           = accept;
        q_entry.port_sel = 1'b1;
        q_entry.num      = '0;
      end else if (prev_s <= lo_s) begin
        q_push           = accept;
        q_entry.port_sel = 1'b0;
        q_entry.num      = ONE;
      end
    end else begin
      q_push = accept;
      if (accept) begin
        last_out_nxt = in_sample;
      end
      if (num_s <= 0 || den_s <= 0) begin
        q_entry.num = '0;
      end else if (num_s >= den2_s) begin
        // Quotient is at least two, so it saturates.
        q_entry.num = ONE;
      end else begin
        q_entry.kind = KIND_DIV;
        q_entry.num  = num_s[W-1:0];
      end
    end
  end

  always_comb begin
    split_point_nxt = split_point_r;
    dead_width_nxt  = dead_width_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SPLIT) begin
        split_point_nxt = cfg_data;
      end else if (cfg_index == REG_DEAD) begin
        dead_width_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_point_r <= SPLIT_RST;
      dead_width_r  <= '0;
      last_out_r    <= '0;
    end else begin
      split_point_r <= split_point_nxt;
      dead_width_r  <= dead_width_nxt;
      last_out_r    <= last_out_nxt;
    end
  end

endmodule

/* src/dzvs_queue.sv */
module dzvs_queue import dzvs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t stat
);

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/dzvs_back.sv */
module dzvs_back import dzvs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  q_stat_t      q_stat,
  input  entry_t       q_head,
  output logic         q_pop,
  input  logic         out_pop,
  output logic         out_empty,
  output logic         out_port_select,
  output logic [W-1:0] out_scaled_value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W+1:0]   rem_r, rem_nxt;
  logic [W-1:0]   den_r, den_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic           sel_r, sel_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_sel_r, out_sel_nxt;
  logic [W-1:0]   out_val_r, out_val_nxt;

  logic           ge;
  logic [W+1:0]   diff;

  assign out_empty        = !out_valid_r;
  assign out_port_select  = out_sel_r;
  assign out_scaled_value = out_val_r;

  // One restoring step: the remainder stays below twice the divisor.
  assign ge   = (rem_r >= {2'b00, den_r});
  assign diff = ge ? (rem_r - {2'b00, den_r}) : rem_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    sel_nxt       = sel_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_pop;
    out_sel_nxt   = out_sel_r;
    out_val_nxt   = out_val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          sel_nxt = q_head.port_sel;
          if (q_head.kind == KIND_DIV) begin
            rem_nxt   = {2'b00, q_head.num};
            den_nxt   = q_head.den;
            cnt_nxt   = CNT_W'(W - 1);
            state_nxt = ST_DIV;
          end else begin
            quo_nxt   = q_head.num;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        quo_nxt = {quo_r[W-2:0], ge};
        rem_nxt = {diff[W:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = sel_r;
          out_val_nxt   = (quo_r > ONE) ? ONE : quo_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    sel_r     <= sel_nxt;
    out_sel_r <= out_sel_nxt;
    out_val_r <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/dead_zone_value_splitter.sv */
// A sample that needs a division is popped from the queue and loaded into the 17-step serial
// divider, then written to the output register once the output is free; border, zero and
// saturated results skip the divider. A new request is taken only after the last is written out.
// A two-entry request queue lets the input side run ahead of the divider.
// Synchronous active-low reset clears the queue, the output and the last outside value,
// and sets split point to one half and dead width to zero.
module dead_zone_value_splitter import dzvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [W-1:0]         cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [W-1:0]         in_sample,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_port_select,
  output logic [W-1:0]         out_scaled_value
);

  q_stat_t q_stat;
  entry_t  q_entry;
  entry_t  q_head;
  logic    q_push;
  logic    q_pop;

  assign in_full = q_stat.full;

  dzvs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .in_push   (in_push),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  dzvs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  dzvs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_port_select  (out_port_select),
    .out_scaled_value (out_scaled_value)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  a_result_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_scaled_value <= ONE))
    else $error("scaled value above full scale");

endmodule
